// ----- design/cartridge_bank_controller_unit_macros.svh -----
// Assertion macros shared by the cartridge bank controller RTL.
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cartridge bank controller check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cartridge bank controller check failed");
`else
`define CBC_ASSERT_NOW(lbl, ante, cons)
`define CBC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/cbc_pkg.sv -----
// Shared constants and helpers for the cartridge bank controller.
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

  localparam int RAM_BANKS_DEF      = 4;
  localparam int RAM_BANK_BYTES_DEF = 8192;

  // Access kinds on the input channel.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ROM   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // 8 KiB regions, selected by bus address bits 15:13.
  localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
  localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
  localparam logic [2:0] REGION_RAM_BANK   = 3'd2;
  localparam logic [2:0] REGION_MODE       = 3'd3;
  localparam logic [2:0] REGION_CART_RAM   = 3'd5;

  // Configuration register indexes (bit 2 of the byte address).
  localparam logic REG_RAM_SIZE_CODE   = 1'b0;
  localparam logic REG_BATTERY_PRESENT = 1'b1;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;
  localparam logic [4:0] ROM_BANK_MIN   = 5'd1;

  // Banks present for a header RAM size code.
  function automatic logic [2:0] banks_for_code(input logic [2:0] code);
    logic [2:0] banks;
    unique case (code)
      3'd2:                 banks = 3'd1;
      3'd3, 3'd4, 3'd5:     banks = 3'd4;
      default:              banks = 3'd0;
    endcase
    return banks;
  endfunction

endpackage

`default_nettype wire

// ----- design/cbc_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none

module cbc_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 32768,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- design/cartridge_bank_controller_unit.sv -----
// Top level of the cartridge bank controller: bank registers, cartridge RAM, result queue.
//
//   channel | direction | transfer condition          | payload
//   --------+-----------+-----------------------------+----------------------------------------
//   in_     | in        | in_valid && in_ready        | cmd, bus_address, write_byte
//   out_    | out       | out_valid && out_ready      | result_kind, read_byte, rom_address,
//           |           |                             | save_pending
//   cfg     | in        | psel && penable && pwrite   | ram_size_code (0x0), battery_present (0x4)
//
// One access per cycle sustained while in_ready is high; clearing and a full result queue hold it off.
// A result passes through s1 and then the head of the result queue before it is on out_.
// Each access issues at most one cartridge RAM read or one RAM write at its accept edge;
// the RAM registers the read data, and s1 merges it into the result.
// After reset a clearing pass zeroes the cartridge RAM, one byte a cycle, over all
// CART_BANKS * RAM_BANK_BYTES bytes (32768 by default); in_ready stays low meanwhile,
// configuration writes are taken as usual.
// A two-entry result queue lets in_ready depend only on registers; with the queue full
// and an access held in s1, in_ready drops until out_ready frees a slot.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_controller_unit #(
  parameter int CART_BANKS     = cbc_pkg::RAM_BANKS_DEF,
  parameter int RAM_BANK_BYTES = cbc_pkg::RAM_BANK_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // access channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [15:0] in_bus_address,
  input  wire logic [7:0]  in_write_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_read_byte,
  output logic [18:0]      out_rom_address,
  output logic             out_save_pending,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

`include "cartridge_bank_controller_unit_macros.svh"

  localparam int DEPTH = CART_BANKS * RAM_BANK_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int OFS_W = $clog2(RAM_BANK_BYTES);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rd;
    logic [18:0] rom;
    logic        save;
  } res_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0] ram_size_code_r;
  logic       battery_present_r;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_size_code_r   <= '0;
      battery_present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        cbc_pkg::REG_RAM_SIZE_CODE:   ram_size_code_r   <= pwdata[2:0];
        cbc_pkg::REG_BATTERY_PRESENT: battery_present_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Reads ignore the low address bits, like writes.
  always_comb begin
    unique case (paddr[2])
      cbc_pkg::REG_RAM_SIZE_CODE:   prdata = {29'd0, ram_size_code_r};
      cbc_pkg::REG_BATTERY_PRESENT: prdata = {31'd0, battery_present_r};
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Bank state
  // ---------------------------------------------------------------------------
  logic       ram_en_r,   ram_en_nxt;
  logic [4:0] rom_bank_r, rom_bank_nxt;
  logic [1:0] ram_bank_r, ram_bank_nxt;
  logic       mode_r,     mode_nxt;
  logic       dirty_r,    dirty_nxt;

  // Clearing pass after reset
  logic          clear_r;
  logic [AW-1:0] clr_cnt_r;

  // Pipeline: s1 holds an accepted access while its RAM read completes, and until the result queue has room.
  logic s1_valid_r, s1_valid_nxt;
  res_t s1_res_r;
  logic s1_use_ram_r;
  logic s1_move;

  // Two-entry result queue: head drives the ports, skid behind it.
  logic out_valid_r,  skid_valid_r;
  res_t out_res_r,    skid_res_r;
  logic queue_full, pop;
  res_t push_res;

  logic in_fire;
  logic [2:0] region;
  logic [1:0] act_bank;
  logic [2:0] present_raw, present;
  logic       ram_hit;
  logic [OFS_W+1:0] ram_addr_wide;
  logic [AW-1:0]    ram_addr;
  logic       item_we, item_re, use_ram_d;
  res_t       res_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign queue_full = out_valid_r && skid_valid_r;
  assign in_ready   = !clear_r && (!s1_valid_r || !queue_full);
  assign in_fire    = in_valid && in_ready;
  assign s1_move    = s1_valid_r && !queue_full;
  assign pop        = out_valid_r && out_ready;

  // Active RAM bank: mode 0 pins bank 0; absent banks miss.
  assign region      = in_bus_address[15:13];
  assign act_bank    = mode_r ? ram_bank_r : 2'd0;
  assign present_raw = cbc_pkg::banks_for_code(ram_size_code_r);
  assign present     = (present_raw > 3'(CART_BANKS)) ? 3'(CART_BANKS) : present_raw;
  assign ram_hit     = ram_en_r && ({1'b0, act_bank} < present);
  assign ram_addr_wide = {act_bank, in_bus_address[OFS_W-1:0]};
  assign ram_addr      = ram_addr_wide[AW-1:0];

  // Decode the access at its transfer edge against the current bank state.
  always_comb begin
    ram_en_nxt   = ram_en_r;
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    mode_nxt     = mode_r;
    dirty_nxt    = dirty_r;
    item_we      = 1'b0;
    item_re      = 1'b0;
    use_ram_d    = 1'b0;
    res_d.kind   = cbc_pkg::KIND_WRITE;
    res_d.rd     = '0;
    res_d.rom    = '0;
    if (in_fire) begin
      if (in_cmd == cbc_pkg::CMD_WRITE) begin
        unique case (region)
          cbc_pkg::REGION_RAM_ENABLE:
            ram_en_nxt = (in_write_byte[3:0] == cbc_pkg::RAM_ENABLE_KEY);
          cbc_pkg::REGION_ROM_BANK:
            // remap bank zero to one after masking
            rom_bank_nxt = (in_write_byte[4:0] == 5'd0) ? cbc_pkg::ROM_BANK_MIN
                                                          : in_write_byte[4:0];
          cbc_pkg::REGION_RAM_BANK:
            ram_bank_nxt = in_write_byte[1:0];
          cbc_pkg::REGION_MODE:
            mode_nxt = in_write_byte[0];
          cbc_pkg::REGION_CART_RAM: begin
            if (ram_hit) begin
              item_we   = 1'b1;
              dirty_nxt = dirty_r || battery_present_r;
            end
          end
          default: ;
        endcase
      end else if (!in_bus_address[15]) begin
        res_d.kind = cbc_pkg::KIND_ROM;
        res_d.rom  = in_bus_address[14] ? {rom_bank_r, in_bus_address[13:0]}
                                        : {5'd0, in_bus_address[13:0]};
      end else if (region == cbc_pkg::REGION_CART_RAM) begin
        res_d.kind = cbc_pkg::KIND_READ;
        if (ram_hit) begin
          item_re   = 1'b1;
          use_ram_d = 1'b1;
        end else begin
          res_d.rd = cbc_pkg::OPEN_BUS_BYTE;
        end
      end else begin
        res_d.kind = cbc_pkg::KIND_READ;
        res_d.rd   = cbc_pkg::OPEN_BUS_BYTE;
      end
    end
    res_d.save = dirty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_en_r   <= 1'b0;
      rom_bank_r <= cbc_pkg::ROM_BANK_MIN;
      ram_bank_r <= '0;
      mode_r     <= 1'b0;
      dirty_r    <= 1'b0;
    end else begin
      ram_en_r   <= ram_en_nxt;
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      mode_r     <= mode_nxt;
      dirty_r    <= dirty_nxt;
    end
  end

  // Sweep zeros through the RAM, then hand the write port to accesses.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clear_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  assign ram_we    = clear_r || item_we;
  assign ram_waddr = clear_r ? clr_cnt_r : ram_addr;
  assign ram_wdata = clear_r ? 8'd0 : in_write_byte;

  // A write lands at its transfer edge, so a read accepted at a later edge already sees it.
  cbc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_cart_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (item_re),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // s1: hold the access until the queue has room; RAM read data stays put
  // because no new read issues while s1 is stalled.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res_r     <= res_d;
      s1_use_ram_r <= use_ram_d;
    end
  end

  always_comb begin
    push_res    = s1_res_r;
    push_res.rd = s1_use_ram_r ? ram_rdata : s1_res_r.rd;
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= s1_move;
      end else begin
        out_valid_r <= s1_move;
      end
    end else if (s1_move) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
        if (s1_move) begin
          skid_res_r <= push_res;
        end
      end else if (s1_move) begin
        out_res_r <= push_res;
      end
    end else if (s1_move) begin
      if (!out_valid_r) begin
        out_res_r <= push_res;
      end else begin
        skid_res_r <= push_res;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_res_r.kind;
  assign out_read_byte    = out_res_r.rd;
  assign out_rom_address  = out_res_r.rom;
  assign out_save_pending = out_res_r.save;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `CBC_ASSERT_NOW(a_no_access_while_clearing, clear_r, !in_ready)
  `CBC_ASSERT_NOW(a_skid_behind_head, skid_valid_r, out_valid_r)
  `CBC_ASSERT_NEXT(a_dirty_sticky, dirty_r, dirty_r)
  `CBC_ASSERT_NOW(a_rom_bank_nonzero, 1'b1, rom_bank_r != 5'd0)
  `CBC_ASSERT_NEXT(a_stalled_s1_holds, s1_valid_r && queue_full && !pop,
                   s1_valid_r && !item_re)

endmodule

`default_nettype wire
